// ----- rtl/core/clb_pkg.sv -----
// package for the cursor line edit buffer: widths, codes and shared structs
`timescale 1ns / 1ps

package clb_pkg;

  // line store geometry
  localparam int LINE_DEPTH = 64;
  localparam int ADDR_W     = $clog2(LINE_DEPTH);
  localparam int LEN_W      = $clog2(LINE_DEPTH + 1);

  // field widths
  localparam int CMD_W    = 3;
  localparam int CHAR_W   = 8;
  localparam int STAT_W   = 2;
  localparam int CURSOR_W = 6;
  localparam int MAXC_W   = 7;
  localparam int CMP_W    = (LEN_W > MAXC_W) ? LEN_W : MAXC_W;

  // stream widths, rounded up to whole bytes
  localparam int IN_TDATA_W  = ((CMD_W + CHAR_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((CHAR_W + CURSOR_W + 7) / 8) * 8;

  localparam logic [MAXC_W-1:0] MAXC_RESET = MAXC_W'(64);

  // command codes
  localparam logic [CMD_W-1:0] CMD_PRINT  = 3'd0;
  localparam logic [CMD_W-1:0] CMD_INSERT = 3'd1;
  localparam logic [CMD_W-1:0] CMD_DELETE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_LEFT   = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RIGHT  = 3'd4;

  // status codes
  localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
  localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd1;
  localparam logic [STAT_W-1:0] STAT_FULL  = 2'd2;

  typedef struct packed {
    logic [CHAR_W-1:0]   char_out;
    logic                last;
    logic [STAT_W-1:0]   status;
    logic [CURSOR_W-1:0] cursor_pos;
  } clb_result_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CHAR_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } clb_ram_req_t;

  typedef struct packed {
    logic [1:0] level;
    logic       pop;
  } clb_fifo_stat_t;

endpackage

// ----- rtl/core/clb_line_ram.sv -----
// simple dual port line store, one write and one registered read per cycle
`timescale 1ns / 1ps

module clb_line_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- rtl/core/clb_out_fifo.sv -----
// two entry result queue between the sequencer and the output stream
`timescale 1ns / 1ps

module clb_out_fifo (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  input  clb_pkg::clb_result_t   push_data,
  input  logic                   out_ready,
  output logic                   out_valid,
  output clb_pkg::clb_result_t   out_data,
  output clb_pkg::clb_fifo_stat_t stat
);

  import clb_pkg::*;

  clb_result_t slot0_r, slot0_nxt;
  clb_result_t slot1_r, slot1_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        pop;

  assign pop       = (cnt_r != 2'd0) && out_ready;
  assign out_valid = (cnt_r != 2'd0);
  assign out_data  = slot0_r;
  assign stat      = '{level: cnt_r, pop: pop};

  // slot0 is always the head
  always_comb begin
    slot0_nxt = slot0_r;
    slot1_nxt = slot1_r;
    cnt_nxt   = cnt_r;
    if (push && pop) begin
      if (cnt_r == 2'd1) begin
        slot0_nxt = push_data;
      end else begin
        slot0_nxt = slot1_r;
        slot1_nxt = push_data;
      end
    end else if (pop) begin
      slot0_nxt = slot1_r;
      cnt_nxt   = cnt_r - 2'd1;
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        slot0_nxt = push_data;
      end else begin
        slot1_nxt = push_data;
      end
      cnt_nxt = cnt_r + 2'd1;
    end
  end

  // payload slots
  always_ff @(posedge clk) begin
    slot0_r <= slot0_nxt;
    slot1_r <= slot1_nxt;
  end

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  no_overflow_a : assert property (@(posedge clk) disable iff (!rst_n)
    (cnt_r == 2'd2 && push) |-> pop)
    else $error("result queue overflow");

  no_underflow_a : assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("result queue count out of range");

  count_step_a : assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> cnt_r == $past(cnt_r) + 2'd1)
    else $error("result queue count did not follow push");

endmodule

// ----- rtl/core/clb_ctrl.sv -----
// command sequencer: decodes a request, walks the line store and emits results
`timescale 1ns / 1ps

module clb_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [clb_pkg::CMD_W-1:0]  cmd,
  input  logic [clb_pkg::CHAR_W-1:0] char_in,
  input  logic                       cfg_wr_en,
  input  logic [clb_pkg::MAXC_W-1:0] cfg_wr_data,
  output clb_pkg::clb_ram_req_t      ram_req,
  input  logic [clb_pkg::CHAR_W-1:0] ram_rdata,
  input  clb_pkg::clb_fifo_stat_t    fifo_stat,
  output logic                       res_push,
  output clb_pkg::clb_result_t       res_data
);

  import clb_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SHUP   = 3'd1;
  localparam logic [2:0] ST_SHDN   = 3'd2;
  localparam logic [2:0] ST_DRAIN  = 3'd3;
  localparam logic [2:0] ST_PUT    = 3'd4;
  localparam logic [2:0] ST_PRINT  = 3'd5;
  localparam logic [2:0] ST_RESULT = 3'd6;

  logic [2:0]        state_r, state_nxt;
  logic [ADDR_W-1:0] rp_r, rp_nxt;
  logic [ADDR_W-1:0] stop_r, stop_nxt;
  logic [ADDR_W-1:0] pos_r, pos_nxt;
  logic [CHAR_W-1:0] char_r, char_nxt;
  logic              ins_r, ins_nxt;
  logic [STAT_W-1:0] status_r, status_nxt;
  logic [LEN_W-1:0]  len_r, len_nxt;
  logic [ADDR_W-1:0] cur_r, cur_nxt;
  logic              before_r, before_nxt;
  logic [MAXC_W-1:0] maxc_r;
  logic              inflight_r, inflight_nxt;
  logic              rd_last_r, rd_last_nxt;
  logic              wpend_r, wpend_nxt;
  logic [ADDR_W-1:0] waddr_r, waddr_nxt;

  logic              accept;
  logic              space;
  logic [2:0]        occupancy;
  logic [CMP_W-1:0]  cap;
  logic              full;
  logic [ADDR_W-1:0] last_idx;
  logic [ADDR_W-1:0] ins_pos;
  logic [ADDR_W-1:0] del_pos;
  logic              del_move;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;

  assign in_ready = (state_r == ST_IDLE);
  assign accept   = in_valid && in_ready;

  // room in the result queue for one more entry, counting the read in flight
  assign occupancy = {1'b0, fifo_stat.level} + {2'b00, inflight_r} - {2'b00, fifo_stat.pop};
  assign space     = (occupancy < 3'd2);

  // capacity is the configured limit clamped to the store depth
  assign cap  = (CMP_W'(maxc_r) > CMP_W'(LINE_DEPTH)) ? CMP_W'(LINE_DEPTH) : CMP_W'(maxc_r);
  assign full = (CMP_W'(len_r) >= cap);

  assign last_idx = ADDR_W'(len_r - LEN_W'(1));
  assign ins_pos  = (len_r == '0) ? '0 : (before_r ? cur_r : cur_r + ADDR_W'(1));
  assign del_pos  = before_r ? cur_r - ADDR_W'(1) : cur_r;
  assign del_move = !before_r || (cur_r != '0);

  // next state and command decode
  always_comb begin
    state_nxt    = state_r;
    rp_nxt       = rp_r;
    stop_nxt     = stop_r;
    pos_nxt      = pos_r;
    char_nxt     = char_r;
    ins_nxt      = ins_r;
    status_nxt   = status_r;
    len_nxt      = len_r;
    cur_nxt      = cur_r;
    before_nxt   = before_r;
    inflight_nxt = 1'b0;
    rd_last_nxt  = rd_last_r;
    wpend_nxt    = 1'b0;
    waddr_nxt    = waddr_r;
    rd_en        = 1'b0;
    rd_addr      = rp_r;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          status_nxt = STAT_OK;
          char_nxt   = char_in;
          ins_nxt    = 1'b0;
          state_nxt  = ST_RESULT;
          unique case (cmd)
            CMD_PRINT: begin
              if (len_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else begin
                rp_nxt    = '0;
                stop_nxt  = last_idx;
                state_nxt = ST_PRINT;
              end
            end
            CMD_INSERT: begin
              if (full) begin
                status_nxt = STAT_FULL;
              end else begin
                ins_nxt = 1'b1;
                pos_nxt = ins_pos;
                rp_nxt  = last_idx;
                stop_nxt = ins_pos;
                len_nxt = len_r + LEN_W'(1);
                cur_nxt = (len_r == '0) ? '0 : cur_r + ADDR_W'(1);
                state_nxt = (LEN_W'(ins_pos) == len_r) ? ST_PUT : ST_SHUP;
              end
            end
            CMD_DELETE: begin
              if (len_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else if (del_move) begin
                len_nxt = len_r - LEN_W'(1);
                if (len_r == LEN_W'(1)) begin
                  cur_nxt = '0;
                end else if (cur_r != '0) begin
                  cur_nxt = cur_r - ADDR_W'(1);
                end
                rp_nxt   = del_pos + ADDR_W'(1);
                stop_nxt = last_idx;
                if (del_pos != last_idx) begin
                  state_nxt = ST_SHDN;
                end
              end
            end
            CMD_LEFT: begin
              if (len_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else if (!before_r) begin
                before_nxt = 1'b1;
              end else if (cur_r != '0) begin
                cur_nxt = cur_r - ADDR_W'(1);
              end
            end
            CMD_RIGHT: begin
              if (len_r == '0) begin
                status_nxt = STAT_EMPTY;
              end else if (before_r) begin
                before_nxt = 1'b0;
              end else if (LEN_W'(cur_r) + LEN_W'(1) < len_r) begin
                cur_nxt = cur_r + ADDR_W'(1);
              end
            end
            default: begin
              status_nxt = STAT_OK;
            end
          endcase
        end
      end
      // move characters up one place, walking down from the end
      ST_SHUP: begin
        rd_en     = 1'b1;
        wpend_nxt = 1'b1;
        waddr_nxt = rp_r + ADDR_W'(1);
        if (rp_r == stop_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          rp_nxt = rp_r - ADDR_W'(1);
        end
      end
      // move characters down one place, walking up to the end
      ST_SHDN: begin
        rd_en     = 1'b1;
        wpend_nxt = 1'b1;
        waddr_nxt = rp_r - ADDR_W'(1);
        if (rp_r == stop_r) begin
          state_nxt = ST_DRAIN;
        end else begin
          rp_nxt = rp_r + ADDR_W'(1);
        end
      end
      ST_DRAIN: begin
        state_nxt = ins_r ? ST_PUT : ST_RESULT;
      end
      ST_PUT: begin
        state_nxt = ST_RESULT;
      end
      // one read per cycle while the result queue has room
      ST_PRINT: begin
        if (space) begin
          rd_en        = 1'b1;
          inflight_nxt = 1'b1;
          rd_last_nxt  = (rp_r == stop_r);
          if (rp_r == stop_r) begin
            state_nxt = ST_IDLE;
          end else begin
            rp_nxt = rp_r + ADDR_W'(1);
          end
        end
      end
      ST_RESULT: begin
        if (space && !inflight_r) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // store accesses: the walk read, then a shifted character or the inserted byte
  always_comb begin
    ram_req.re    = rd_en;
    ram_req.raddr = rd_addr;
    ram_req.we    = 1'b0;
    ram_req.waddr = waddr_r;
    ram_req.wdata = ram_rdata;
    if (wpend_r) begin
      ram_req.we = 1'b1;
    end else if (state_r == ST_PUT) begin
      ram_req.we    = 1'b1;
      ram_req.waddr = pos_r;
      ram_req.wdata = char_r;
    end
  end

  // result to the queue: a printed character or the single command result
  always_comb begin
    res_push = inflight_r || ((state_r == ST_RESULT) && space);
    res_data.cursor_pos = CURSOR_W'(cur_r);
    if (inflight_r) begin
      res_data.char_out = ram_rdata;
      res_data.last     = rd_last_r;
      res_data.status   = STAT_OK;
    end else begin
      res_data.char_out = '0;
      res_data.last     = 1'b1;
      res_data.status   = status_r;
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      len_r      <= '0;
      cur_r      <= '0;
      before_r   <= 1'b0;
      maxc_r     <= MAXC_RESET;
      inflight_r <= 1'b0;
      wpend_r    <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      len_r      <= len_nxt;
      cur_r      <= cur_nxt;
      before_r   <= before_nxt;
      inflight_r <= inflight_nxt;
      wpend_r    <= wpend_nxt;
      if (cfg_wr_en) begin
        maxc_r <= cfg_wr_data;
      end
    end
  end

  // working registers
  always_ff @(posedge clk) begin
    rp_r      <= rp_nxt;
    stop_r    <= stop_nxt;
    pos_r     <= pos_nxt;
    char_r    <= char_nxt;
    ins_r     <= ins_nxt;
    status_r  <= status_nxt;
    rd_last_r <= rd_last_nxt;
    waddr_r   <= waddr_nxt;
  end

  shift_no_collide_a : assert property (@(posedge clk) disable iff (!rst_n)
    (ram_req.we && ram_req.re) |-> (ram_req.waddr != ram_req.raddr))
    else $error("store read and write hit the same entry");

  len_in_range_a : assert property (@(posedge clk) disable iff (!rst_n)
    len_r <= LEN_W'(LINE_DEPTH))
    else $error("line length beyond store depth");

  cursor_in_line_a : assert property (@(posedge clk) disable iff (!rst_n)
    (len_r != '0) |-> (LEN_W'(cur_r) < len_r))
    else $error("cursor outside the line");

  cursor_empty_a : assert property (@(posedge clk) disable iff (!rst_n)
    (len_r == '0) |-> (cur_r == '0))
    else $error("cursor not at zero on an empty line");

  push_has_room_a : assert property (@(posedge clk) disable iff (!rst_n)
    res_push |-> (fifo_stat.level != 2'd2 || fifo_stat.pop))
    else $error("result pushed into a full queue");

endmodule

// ----- rtl/core/cursor_line_edit_buffer_top.sv -----
// top level of the cursor line edit buffer: stream ports, store, sequencer, result queue
`timescale 1ns / 1ps

// One line of up to max_chars bytes (at most 64) with a cursor and a side flag, driven by
// one command request at a time. The block takes a request only when the previous one has
// finished its work; results leave through a two entry queue, so a waiting result does not
// hold up the next request. The line lives in a memory with one write and one registered
// read port, and every shift or print walks it one entry per cycle, print only while the
// result queue has room. Print delivers one character per cycle while the output keeps up;
// insert writes the byte directly when it lands at the end of the line and otherwise first
// moves the characters after the insert point up, delete moves the characters after the
// removed one down unless nothing has to move, and left, right and rejected commands only
// update the cursor or report a status. Nothing needs clearing after reset: only entries
// below the live length are ever read.

module cursor_line_edit_buffer_top (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [clb_pkg::IN_TDATA_W-1:0]      in_tdata,   // cmd[2:0], char_in[10:3]
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [clb_pkg::OUT_TDATA_W-1:0]     out_tdata,  // char_out[7:0], cursor_pos[13:8]
  output logic                                out_tlast,
  output logic [clb_pkg::STAT_W-1:0]          out_tuser,  // status[1:0]
  input  logic                                cfg_wr_en,
  input  logic [clb_pkg::MAXC_W-1:0]          cfg_wr_data
);

  import clb_pkg::*;

  clb_ram_req_t      ram_req;
  logic [CHAR_W-1:0] ram_rdata;
  clb_fifo_stat_t    fifo_stat;
  logic              res_push;
  clb_result_t       res_data;
  clb_result_t       head;

  // command sequencer
  clb_ctrl u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_tvalid),
    .in_ready    (in_tready),
    .cmd         (in_tdata[CMD_W-1:0]),
    .char_in     (in_tdata[CMD_W+CHAR_W-1:CMD_W]),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .ram_req     (ram_req),
    .ram_rdata   (ram_rdata),
    .fifo_stat   (fifo_stat),
    .res_push    (res_push),
    .res_data    (res_data)
  );

  // line store
  clb_line_ram #(
    .DEPTH (LINE_DEPTH),
    .WIDTH (CHAR_W)
  ) u_ram (
    .clk   (clk),
    .we    (ram_req.we),
    .waddr (ram_req.waddr),
    .wdata (ram_req.wdata),
    .re    (ram_req.re),
    .raddr (ram_req.raddr),
    .rdata (ram_rdata)
  );

  // result queue
  clb_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (res_push),
    .push_data (res_data),
    .out_ready (out_tready),
    .out_valid (out_tvalid),
    .out_data  (head),
    .stat      (fifo_stat)
  );

  // output packing
  assign out_tdata = OUT_TDATA_W'({head.cursor_pos, head.char_out});
  assign out_tlast = head.last;
  assign out_tuser = head.status;

endmodule
